// File: design/crcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-16/CCITT byte update for the frame
// receiver.
// ---------------------------------------------------------------------------
package crcfr_pkg;

  // CRC-16/CCITT-FALSE: poly 0x1021, init 0xFFFF, no reflection, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam int          CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'b1;
  localparam int          CFG_DATA_W       = 16;

  // Register reset values
  localparam logic [7:0]  START_BYTE_RST  = 8'hAA;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  // Frame status codes
  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_GOOD     = 2'd1;
  localparam logic [1:0] STAT_CRC_BAD  = 2'd2;
  localparam logic [1:0] STAT_OVERSIZE = 2'd3;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // One classified byte in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
  } q_item_t;

  // One result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_end;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
  } result_t;

  // One byte through the CRC, MSB first, eight unrolled shift steps
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/crcfr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crcfr_rx_if / crcfr_res_if
// Valid/ready channels for received bytes and for result items.
// ---------------------------------------------------------------------------
interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_end;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;

  modport source (output valid, output payload_byte, output payload_valid,
                  output frame_end, output status, output frame_type,
                  output frame_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input frame_end, input status, input frame_type,
                  input frame_length, output ready);
endinterface
`default_nettype wire

// File: design/crcfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crcfr_front
// Holds the configuration registers, accepts received bytes and tags each
// one with a start-byte match before it enters the queue.
// ---------------------------------------------------------------------------
module crcfr_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data,
  crcfr_rx_if.sink                              rx,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output crcfr_pkg::q_item_t                    q_item,
  output logic [15:0]                           max_payload
);
  import crcfr_pkg::*;

  logic [7:0] start_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= START_BYTE_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:  start_byte  <= cfg_data[7:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Accept while the queue has room; classify the byte on the way in
  assign rx.ready        = ~q_full;
  assign q_push          = rx.valid & ~q_full;
  assign q_item.data     = rx.rx_byte;
  assign q_item.is_start = (rx.rx_byte == start_byte);

endmodule
`default_nettype wire

// File: design/crcfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crcfr_queue
// Short FIFO of classified bytes between the front and the parser.
// ---------------------------------------------------------------------------
module crcfr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire crcfr_pkg::q_item_t  push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output crcfr_pkg::q_item_t       pop_item
);
  import crcfr_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_item_t             entries [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/crcfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crcfr_back
// Frame parser: header, payload and CRC fields, running CRC, verdict and the
// registered result stage.
// ---------------------------------------------------------------------------
module crcfr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire crcfr_pkg::q_item_t q_item,
  output logic                    q_pop,
  input  wire logic [15:0]        max_payload,
  crcfr_res_if.source             res
);
  import crcfr_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_TYPE    = 3'd1,
    ST_LEN_LO  = 3'd2,
    ST_LEN_HI  = 3'd3,
    ST_PAYLOAD = 3'd4,
    ST_CRC_LO  = 3'd5,
    ST_CRC_HI  = 3'd6
  } state_t;

  state_t      state, state_next;
  logic [7:0]  type_reg, type_next;
  logic [15:0] length_reg, length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  crc_low_byte, crc_low_next;
  logic [15:0] running_crc, crc_next;
  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic        clear_after;
  logic        res_valid;
  result_t     res_q;
  result_t     res_next;

  // Take a byte whenever the result stage is free or draining
  assign q_pop = q_valid & (~res_valid | res.ready);

  assign crc_upd   = crc_step(running_crc, q_item.data);
  assign count_inc = byte_count + 16'd1;
  assign len_full  = {q_item.data, length_reg[7:0]};

  // Parser next state and result
  always_comb begin
    state_next      = state;
    type_next       = type_reg;
    length_next     = length_reg;
    byte_count_next = byte_count;
    crc_low_next    = crc_low_byte;
    crc_next        = running_crc;
    clear_after     = 1'b0;
    res_next        = '0;

    unique case (state)
      ST_HUNT: begin
        if (q_item.is_start) begin
          crc_next   = CRC_INIT;
          state_next = ST_TYPE;
        end
      end
      ST_TYPE: begin
        type_next  = q_item.data;
        crc_next   = crc_upd;
        state_next = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        length_next = {8'h00, q_item.data};
        crc_next    = crc_upd;
        state_next  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        length_next = len_full;
        crc_next    = crc_upd;
        if (len_full == 16'd0) begin
          state_next = ST_CRC_LO;
        end else if (len_full > max_payload) begin
          res_next.frame_end = 1'b1;
          res_next.status    = STAT_OVERSIZE;
          clear_after        = 1'b1;
        end else begin
          byte_count_next = 16'd0;
          state_next      = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        res_next.payload_byte  = q_item.data;
        res_next.payload_valid = 1'b1;
        crc_next               = crc_upd;
        byte_count_next        = count_inc;
        if (count_inc >= length_reg) begin
          state_next = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        crc_low_next = q_item.data;
        state_next   = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        res_next.frame_end = 1'b1;
        res_next.status    = ({q_item.data, crc_low_byte} == running_crc) ?
                             STAT_GOOD : STAT_CRC_BAD;
        clear_after        = 1'b1;
      end
      default: begin
        // unreachable code: drop the byte and start over
        state_next      = ST_HUNT;
        type_next       = '0;
        length_next     = '0;
        byte_count_next = '0;
        crc_low_next    = '0;
        crc_next        = CRC_INIT;
      end
    endcase

    // Result shows type and length before any end-of-frame clear
    res_next.frame_type   = type_next;
    res_next.frame_length = length_next;

    if (clear_after) begin
      state_next      = ST_HUNT;
      type_next       = '0;
      length_next     = '0;
      byte_count_next = '0;
      crc_low_next    = '0;
      crc_next        = CRC_INIT;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_HUNT;
      type_reg     <= '0;
      length_reg   <= '0;
      byte_count   <= '0;
      crc_low_byte <= '0;
      running_crc  <= CRC_INIT;
      res_valid    <= 1'b0;
    end else if (q_pop) begin
      state        <= state_next;
      type_reg     <= type_next;
      length_reg   <= length_next;
      byte_count   <= byte_count_next;
      crc_low_byte <= crc_low_next;
      running_crc  <= crc_next;
      res_q        <= res_next;
      res_valid    <= 1'b1;
    end else if (res.ready) begin
      res_valid    <= 1'b0;
    end
  end

  assign res.valid         = res_valid;
  assign res.payload_byte  = res_q.payload_byte;
  assign res.payload_valid = res_q.payload_valid;
  assign res.frame_end     = res_q.frame_end;
  assign res.status        = res_q.status;
  assign res.frame_type    = res_q.frame_type;
  assign res.frame_length  = res_q.frame_length;

endmodule
`default_nettype wire

// File: design/crc16_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// crc16_frame_receiver_top
// Byte-serial deframer: start byte, type, 16-bit LE length, payload and a
// 16-bit LE CRC-16/CCITT over type, length and payload.
//
// Channels: rx takes one received byte per request; res returns exactly one
// result per byte (payload byte when one, frame end and status on the last
// CRC byte or on an oversize length, current frame type and length).
// Configuration: cfg_we with cfg_index 0 writes start_byte, index 1 writes
// max_payload; write only while no bytes are in flight.
// Path: an accepted byte is written into the queue, popped by the parser and
// captured in the result register (one queue stage, one result register).
// Throughput: one byte per cycle while res is taken; the CRC update is one unrolled byte step
// in the parser, so the next byte can follow directly.
// Reset: parser back to hunting for the start byte, CRC to 0xFFFF, the queue
// empties, start_byte returns to 0xAA and max_payload to 256.
// Stall: when res is not taken, the result register holds and the two-entry
// queue keeps accepting bytes until it fills; then rx.ready drops.
// ---------------------------------------------------------------------------
module crc16_frame_receiver_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data,
  crcfr_rx_if.sink                              rx,
  crcfr_res_if.source                           res
);
  import crcfr_pkg::*;

  logic        q_full;
  logic        q_push;
  q_item_t     q_in_item;
  logic        q_pop;
  logic        q_not_empty;
  q_item_t     q_out_item;
  logic [15:0] max_payload;

  crcfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx          (rx),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in_item),
    .max_payload (max_payload)
  );

  crcfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out_item)
  );

  crcfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_item      (q_out_item),
    .q_pop       (q_pop),
    .max_payload (max_payload),
    .res         (res)
  );

endmodule
`default_nettype wire
